/* rtl/pairwise_euclidean_distance_assert.svh */
// Assertion macros shared by the pairwise euclidean distance RTL.
// Depends on nothing; defining NO_ASSERTIONS turns every macro into nothing.
`ifndef PAIRWISE_EUCLIDEAN_DISTANCE_ASSERT_SVH
`define PAIRWISE_EUCLIDEAN_DISTANCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define PED_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication, checked on the rising clock edge outside reset.
`define PED_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define PED_ASSERT_IMP(name, clk, rst_n, pre, post, msg)
`define PED_ASSERT_NXT(name, clk, rst_n, pre, post, msg)
`endif
`endif

/* rtl/ped_pkg.sv */
// Package of the pairwise euclidean distance block: item types, codes, sizes.
// Depends on nothing; the other RTL files but ped_ram and the header use it by scoped names.
package ped_pkg;

	localparam int REF_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 64;
	localparam int VALUE_BITS   = 16;
	localparam int SUM_BITS     = 40;
	localparam int DIST_BITS    = SUM_BITS / 2;
	localparam int ROW_BITS     = 5;
	localparam int COL_BITS     = 6;
	localparam int CFG_COLS_BITS = 7;
	localparam int CFG_ROWS_BITS = 6;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	localparam logic [CFG_COLS_BITS-1:0] COLS_RESET = 7'd64;
	localparam logic [CFG_ROWS_BITS-1:0] ROWS_RESET = 6'd32;

	typedef struct packed {
		logic                         op;
		logic [ROW_BITS-1:0]          ref_row;
		logic [COL_BITS-1:0]          col;
		logic signed [VALUE_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]  out_row;
		logic [DIST_BITS-1:0] distance;
		logic                 last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_RD,
		ST_LD,
		ST_ROOT
	} ped_state_t;

endpackage

/* rtl/ped_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ped_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ped_sqdiff.sv */
// Squared difference and saturating accumulate for one row sum.
// Depends on ped_pkg for the value and sum widths.
module ped_sqdiff (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [ped_pkg::VALUE_BITS-1:0] q,
	input  logic signed [ped_pkg::VALUE_BITS-1:0] r,
	input  logic [ped_pkg::SUM_BITS-1:0]          sum_in,
	output logic [ped_pkg::SUM_BITS-1:0]          sum_new
);

	localparam int DB = ped_pkg::VALUE_BITS + 1;
	localparam int SB = ped_pkg::SUM_BITS;

	logic signed [DB-1:0] diff;
	logic [DB-1:0]        mag;
	logic [2*DB-1:0]      sq;
	logic [2*DB-1:0]      sq_s2;
	logic [SB-1:0]        sum_s2;
	logic [SB:0]          total;

	// The product is registered before the wide add.
	always_comb begin
		diff = DB'(q) - DB'(r);
		mag  = diff[DB-1] ? DB'(-diff) : DB'(diff);
		sq   = (2*DB)'(mag) * (2*DB)'(mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2  <= sq;
			sum_s2 <= sum_in;
		end
	end

	// A carry out of the sum means the true total passed the top; clamp it.
	always_comb begin
		total   = (SB+1)'(sum_s2) + (SB+1)'(sq_s2);
		sum_new = total[SB] ? {SB{1'b1}} : total[SB-1:0];
	end

endmodule

/* rtl/ped_isqrt.sv */
// Iterative floored integer square root, one result bit per cycle.
// Depends on ped_pkg for the sum and root widths.
module ped_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ped_pkg::SUM_BITS-1:0]   operand,
	output logic                           done,
	output logic [ped_pkg::DIST_BITS-1:0]  root
);

	localparam int SB    = ped_pkg::SUM_BITS;
	localparam int RB    = ped_pkg::DIST_BITS;
	localparam int REMB  = RB + 2;
	localparam int STEPS = SB / 2;
	localparam int CB    = $clog2(STEPS);

	logic [SB-1:0]     x_q;
	logic [REMB-1:0]   rem_q;
	logic [RB-1:0]     root_q;
	logic [CB-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [REMB+1:0]   rem_n;
	logic [REMB+1:0]   trial;
	logic              ge;
	logic [REMB-1:0]   rem_next;

	// Bring down the next two bits and try to append a one to the root.
	always_comb begin
		rem_n    = {rem_q, x_q[SB-1 -: 2]};
		trial    = (REMB+2)'({root_q, 2'b01});
		ge       = rem_n >= trial;
		rem_next = ge ? REMB'(rem_n - trial) : REMB'(rem_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CB'(1);
				if (cnt_q == CB'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q    <= {x_q[SB-3:0], 2'b00};
			rem_q  <= rem_next;
			root_q <= {root_q[RB-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/pairwise_euclidean_distance.sv */
// Load item: written to the reference store at the accepting edge; busy stays low.
// Query item: busy while it makes one store read per reference row and drains.
// Final column: then each row in use passes through the bit-serial square root unit.
// Results come one per strobe cycle and cannot be stalled; no reset clearing pass.
// Reset (arst_n low) empties the row sums and restores the register defaults.
// Depends on ped_pkg, ped_ram, ped_sqdiff, ped_isqrt and the assertion header.
`include "pairwise_euclidean_distance_assert.svh"

module pairwise_euclidean_distance #(
	parameter int REF_ROWS = ped_pkg::REF_ROWS_DEF,
	parameter int MAX_COLS = ped_pkg::MAX_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ped_pkg::cmd_t     cmd,
	output logic              result_valid,
	output ped_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// Row and column index widths; the reference store is addressed {row, col}.
	localparam int RW        = (REF_ROWS > 1) ? $clog2(REF_ROWS) : 1;
	localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_SLOTS = 2 ** RW;
	localparam int REF_DEPTH = ROW_SLOTS * (2 ** CW);
	localparam int VB        = ped_pkg::VALUE_BITS;
	localparam int SB        = ped_pkg::SUM_BITS;
	localparam int NCB       = 9;
	localparam int NRB       = 7;

	// ------------------------------------------------------------------
	// Configuration registers. They keep the bits written; the effective
	// column and row counts are clamped into their legal ranges below.
	// ------------------------------------------------------------------
	logic [ped_pkg::CFG_COLS_BITS-1:0] cols_q;
	logic [ped_pkg::CFG_ROWS_BITS-1:0] rows_q;
	logic                              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ped_pkg::COLS_RESET;
			rows_q <= ped_pkg::ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ped_pkg::REG_COLS: cols_q <= pwdata[ped_pkg::CFG_COLS_BITS-1:0];
				ped_pkg::REG_ROWS: rows_q <= pwdata[ped_pkg::CFG_ROWS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ped_pkg::REG_COLS: prdata = 32'(cols_q);
			ped_pkg::REG_ROWS: prdata = 32'(rows_q);
			default:           prdata = '0;
		endcase
	end

	logic [NCB-1:0] ncols;
	logic [NRB-1:0] nrows;

	always_comb begin
		if (cols_q == '0) begin
			ncols = NCB'(1);
		end else if (NCB'(cols_q) > NCB'(MAX_COLS)) begin
			ncols = NCB'(MAX_COLS);
		end else begin
			ncols = NCB'(cols_q);
		end
		if (rows_q == '0) begin
			nrows = NRB'(1);
		end else if (NRB'(rows_q) > NRB'(REF_ROWS)) begin
			nrows = NRB'(REF_ROWS);
		end else begin
			nrows = NRB'(rows_q);
		end
	end

	// ------------------------------------------------------------------
	// Item acceptance. A load goes straight into the reference store and
	// never makes the block busy. A query inside the columns in use starts
	// a pass over every reference row; one beyond them is dropped.
	// ------------------------------------------------------------------
	ped_pkg::ped_state_t state_q, state_d;

	logic take;
	logic load_ok;
	logic query_ok;
	logic ref_we;

	assign busy     = (state_q != ped_pkg::ST_IDLE);
	assign take     = start & !busy;
	assign load_ok  = (32'(cmd.ref_row) < 32'(REF_ROWS)) && (32'(cmd.col) < 32'(MAX_COLS));
	assign query_ok = NCB'(cmd.col) < ncols;
	assign ref_we   = take && (cmd.op == ped_pkg::OP_LOAD) && load_ok;

	logic              acc_go;
	logic [CW-1:0]     col_q;
	logic [VB-1:0]     q_q;
	logic              last_col_q;
	logic [RW-1:0]     r_q;

	assign acc_go = take && (cmd.op == ped_pkg::OP_QUERY) && query_ok;

	always_ff @(posedge clk) begin
		if (acc_go) begin
			col_q      <= CW'(cmd.col);
			q_q        <= cmd.value;
			last_col_q <= NCB'(cmd.col) == (ncols - NCB'(1));
		end
	end

	// ------------------------------------------------------------------
	// Memories. The reference store is read at {row, column of the query};
	// the row sums are read and written back one row per cycle. Each row is
	// touched once per pass, so a write never meets a read of the same row.
	// ------------------------------------------------------------------
	logic [VB-1:0] ref_rdata;
	logic [SB-1:0] sums_rdata;
	logic [SB-1:0] sum_new;
	logic          v_s1, v_s2;
	logic [RW-1:0] r_s1, r_s2;

	ped_ram #(
		.WIDTH(VB),
		.DEPTH(REF_DEPTH)
	) u_ref_store (
		.clk   (clk),
		.we    (ref_we),
		.waddr ({RW'(cmd.ref_row), CW'(cmd.col)}),
		.wdata (cmd.value),
		.raddr ({r_q, col_q}),
		.rdata (ref_rdata)
	);

	ped_ram #(
		.WIDTH(SB),
		.DEPTH(ROW_SLOTS)
	) u_row_sums (
		.clk   (clk),
		.we    (v_s2),
		.waddr (r_s2),
		.wdata (sum_new),
		.raddr (r_q),
		.rdata (sums_rdata)
	);

	// A row whose valid bit is clear reads as an empty sum. Reset and every
	// column-0 query clear all valid bits at once instead of sweeping memory.
	logic [ROW_SLOTS-1:0] vld_q;
	logic [SB-1:0]        sum_s1;
	logic [SB-1:0]        sum_emit;

	assign sum_s1   = vld_q[r_s1] ? sums_rdata : '0;
	assign sum_emit = vld_q[r_q] ? sums_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (acc_go && (cmd.col == '0)) begin
			vld_q <= '0;
		end else if (v_s2) begin
			vld_q[r_s2] <= 1'b1;
		end
	end

	ped_sqdiff u_sqdiff (
		.clk     (clk),
		.en      (v_s1),
		.q       (q_q),
		.r       (ref_rdata),
		.sum_in  (sum_s1),
		.sum_new (sum_new)
	);

	// ------------------------------------------------------------------
	// Square root and result emission.
	// ------------------------------------------------------------------
	logic                          isq_start;
	logic                          isq_done;
	logic [ped_pkg::DIST_BITS-1:0] isq_root;
	logic                          row_last;

	ped_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (isq_start),
		.operand (sum_emit),
		.done    (isq_done),
		.root    (isq_root)
	);

	assign row_last = NRB'(r_q) == (nrows - NRB'(1));

	// ------------------------------------------------------------------
	// Sequencer. ACC issues one row read per cycle, DRAIN lets the last
	// write-backs land, then on the final column RD/LD/ROOT walk the rows
	// in use through the square root unit.
	// ------------------------------------------------------------------
	logic issue;
	logic r_clr;
	logic r_inc;
	logic emit;

	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		r_clr     = 1'b0;
		r_inc     = 1'b0;
		isq_start = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ped_pkg::ST_IDLE: begin
				if (acc_go) begin
					state_d = ped_pkg::ST_ACC;
					r_clr   = 1'b1;
				end
			end
			ped_pkg::ST_ACC: begin
				issue = 1'b1;
				if (r_q == RW'(REF_ROWS - 1)) begin
					state_d = ped_pkg::ST_DRAIN;
				end else begin
					r_inc = 1'b1;
				end
			end
			ped_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					if (last_col_q) begin
						state_d = ped_pkg::ST_RD;
						r_clr   = 1'b1;
					end else begin
						state_d = ped_pkg::ST_IDLE;
					end
				end
			end
			ped_pkg::ST_RD: begin
				state_d = ped_pkg::ST_LD;
			end
			ped_pkg::ST_LD: begin
				isq_start = 1'b1;
				state_d   = ped_pkg::ST_ROOT;
			end
			ped_pkg::ST_ROOT: begin
				if (isq_done) begin
					emit = 1'b1;
					if (row_last) begin
						state_d = ped_pkg::ST_IDLE;
					end else begin
						r_inc   = 1'b1;
						state_d = ped_pkg::ST_RD;
					end
				end
			end
			default: state_d = ped_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ped_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q          <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (r_clr) begin
				r_q <= '0;
			end else if (r_inc) begin
				r_q <= r_q + RW'(1);
			end
			v_s1         <= issue;
			v_s2         <= v_s1;
			result_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= r_q;
		r_s2 <= r_s1;
		if (emit) begin
			result.out_row  <= ped_pkg::ROW_BITS'(r_q);
			result.distance <= isq_root;
			result.last     <= row_last;
		end
	end

	// Two rows in flight in the accumulate pipeline are never the same row.
	`PED_ASSERT_IMP(a_no_row_overlap, clk, arst_n, v_s1 && v_s2, r_s1 != r_s2, "row sum hazard")
	// Emission only starts once every write-back has landed.
	`PED_ASSERT_IMP(a_drained, clk, arst_n, state_q == ped_pkg::ST_RD, !v_s1 && !v_s2, "emit before drain")
	// A result strobe always follows a finished square root.
	`PED_ASSERT_IMP(a_root_done, clk, arst_n, result_valid, $past(isq_done), "stray result")
	// The final result frees the block; any other result leaves it busy.
	`PED_ASSERT_IMP(a_last_frees, clk, arst_n, result_valid, busy != result.last, "busy after last")

endmodule

/* verif/ped_distance_checker.sv */
// Checker for the pairwise euclidean distance block: predicts distances, compares results.
// Depends on ped_pkg for the item, result and register codes.
module ped_distance_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  ped_pkg::cmd_t     cmd,
	input  logic              result_valid,
	input  ped_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                pending,
	output int                failures
);
	import ped_pkg::*;

	logic [VALUE_BITS-1:0] ref_mem [REF_ROWS_DEF][MAX_COLS_DEF];
	logic [SUM_BITS-1:0]   acc_sums [REF_ROWS_DEF];
	logic [CFG_COLS_BITS-1:0] cols_reg;
	logic [CFG_ROWS_BITS-1:0] rows_reg;
	result_t dist_queue [$];
	int err_count = 0;

	task automatic report_mismatch(input string text);
		$display("%0t: %s", $time, text);
		err_count++;
	endtask

	// Floor of the square root, settled one result bit at a time from the top.
	function automatic logic [DIST_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] x);
		logic [DIST_BITS-1:0] root;
		logic [DIST_BITS-1:0] trial;
		root = '0;
		for (int b = DIST_BITS - 1; b >= 0; b--) begin
			trial = root | (DIST_BITS'(1) << b);
			if (64'(trial) * 64'(trial) <= 64'(x))
				root = trial;
		end
		return root;
	endfunction

	task automatic accumulate_query(input cmd_t c);
		int ncols;
		int nrows;
		logic [VALUE_BITS:0] diff;
		logic [VALUE_BITS:0] mag;
		logic [SUM_BITS:0] acc;
		result_t r;
		ncols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
		nrows = (rows_reg == 0) ? 1 : (rows_reg > REF_ROWS_DEF) ? REF_ROWS_DEF : int'(rows_reg);
		if (int'(c.col) >= ncols)
			return;
		if (c.col == 0) begin
			for (int i = 0; i < REF_ROWS_DEF; i++)
				acc_sums[i] = '0;
		end
		for (int i = 0; i < REF_ROWS_DEF; i++) begin
			diff = {c.value[VALUE_BITS-1], c.value}
				- {ref_mem[i][c.col][VALUE_BITS-1], ref_mem[i][c.col]};
			mag = diff[VALUE_BITS] ? -diff : diff;
			acc = {1'b0, acc_sums[i]} + (SUM_BITS+1)'(mag) * (SUM_BITS+1)'(mag);
			acc_sums[i] = acc[SUM_BITS] ? '1 : acc[SUM_BITS-1:0];
		end
		if (int'(c.col) != ncols - 1)
			return;
		for (int i = 0; i < nrows; i++) begin
			r.out_row  = ROW_BITS'(i);
			r.distance = floor_root(acc_sums[i]);
			r.last     = (i == nrows - 1);
			dist_queue.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REF_ROWS_DEF; i++) begin
				acc_sums[i] = '0;
				for (int j = 0; j < MAX_COLS_DEF; j++)
					ref_mem[i][j] = '0;
			end
			cols_reg = COLS_RESET;
			rows_reg = ROWS_RESET;
			dist_queue.delete();
			pending  <= 0;
			failures <= err_count;
		end else begin
			if (result_valid) begin
				if (dist_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected result for row %0d distance %0d",
						result.out_row, result.distance));
				end else begin
					result_t exp_r;
					exp_r = dist_queue.pop_front();
					if (result.out_row !== exp_r.out_row)
						report_mismatch($sformatf("out_row got %0d expected %0d",
							result.out_row, exp_r.out_row));
					if (result.distance !== exp_r.distance)
						report_mismatch($sformatf("distance of row %0d got %0d expected %0d",
							exp_r.out_row, result.distance, exp_r.distance));
					if (result.last !== exp_r.last)
						report_mismatch($sformatf("last of row %0d got %0b expected %0b",
							exp_r.out_row, result.last, exp_r.last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_COLS)
					cols_reg = pwdata[CFG_COLS_BITS-1:0];
				else
					rows_reg = pwdata[CFG_ROWS_BITS-1:0];
			end
			if (start && !busy) begin
				if (cmd.op == OP_LOAD)
					ref_mem[cmd.ref_row][cmd.col] = cmd.value;
				else
					accumulate_query(cmd);
			end
			pending  <= dist_queue.size();
			failures <= err_count;
		end
	end

endmodule

/* verif/pairwise_euclidean_distance_tb.sv */
// Testbench top for the pairwise euclidean distance block: stimulus, watchdog and verdict.
// Depends on ped_pkg, the block itself and ped_distance_checker.
module pairwise_euclidean_distance_tb;
	import ped_pkg::*;

	// A run is declared hung after this many cycles in which nothing at all is accepted.
	// The longest honest silence is one query plus a full square root pass.
	localparam int QUIET_LIMIT = 4000;
	// The highest column; with every column in use it is the last one of a row.
	localparam int TOP_COL = MAX_COLS_DEF - 1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        result_valid;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int pending;
	int failures;

	// Chance in percent that the sender idles before an item.
	int idle_pct = 11;
	// Register values as last written, used to shape the query rows.
	int cur_cols = 64;
	int cur_rows = 32;
	int quiet_cycles = 0;

	pairwise_euclidean_distance DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	ped_distance_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.pending      (pending),
		.failures     (failures)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The watchdog counts cycles in which no item, no result and no register access
	// is accepted. Reaching the limit means the block has stopped making progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Register values of 0 and above the maximum are clamped by the block.
	function automatic int eff_cols(input int v);
		if (v == 0)
			return 1;
		if (v > MAX_COLS_DEF)
			return MAX_COLS_DEF;
		return v;
	endfunction

	// Mostly random values, with the extremes and zero mixed in now and then.
	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return VALUE_BITS'($urandom());
		endcase
	endfunction

	function automatic cmd_t load_cmd(input int row, input int col, input logic [15:0] v);
		cmd_t c;
		c.op      = OP_LOAD;
		c.ref_row = ROW_BITS'(row);
		c.col     = COL_BITS'(col);
		c.value   = v;
		return c;
	endfunction

	// The row field of a query item is ignored by the block, so it is left random.
	function automatic cmd_t query_cmd(input int col, input logic [15:0] v);
		cmd_t c;
		c.op      = OP_QUERY;
		c.ref_row = ROW_BITS'($urandom());
		c.col     = COL_BITS'(col);
		c.value   = v;
		return c;
	endfunction

	// Offers one item and returns at the edge that accepts it. start is left high so
	// that back-to-back items need no extra cycle; a gap lowers it first.
	task automatic send(input cmd_t c);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Holds the sender off until every predicted distance has come out and the block
	// has gone quiet, then keeps waiting for any trailing work.
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (REF_ROWS_DEF + 8) @(posedge clk);
	endtask

	// One APB write: a setup phase, then an access phase. Bits above the register's
	// width are random, since the block must keep only its own bits.
	task automatic set_reg(input logic idx, input int val);
		logic [31:0] word;
		word = $urandom();
		if (idx == REG_COLS) begin
			word[CFG_COLS_BITS-1:0] = val[CFG_COLS_BITS-1:0];
			cur_cols = int'(val[CFG_COLS_BITS-1:0]);
		end else begin
			word[CFG_ROWS_BITS-1:0] = val[CFG_ROWS_BITS-1:0];
			cur_rows = int'(val[CFG_ROWS_BITS-1:0]);
		end
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Registers only change while nothing is in flight.
	task automatic reconfigure(input int cols, input int rows);
		quiesce();
		set_reg(REG_COLS, cols);
		set_reg(REG_ROWS, rows);
	endtask

	initial begin
		int count;
		int ncols;
		int kind;
		int first_col;
		int cols_pick;
		int rows_pick;
		logic [15:0] v;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A query element reads its column from all reference rows, not only the rows
		// in use, so every column that a query may read is loaded in all rows first.
		// Queries read only columns 0, 1 and the top column; the column counts used
		// below are 1, 2 and all of them.
		for (int r = 0; r < REF_ROWS_DEF; r++) begin
			send(load_cmd(r, 0, pick_value()));
			send(load_cmd(r, 1, pick_value()));
			send(load_cmd(r, TOP_COL, pick_value()));
		end

		// Directed part. Row 0 holds the most negative value and row 31 the most
		// positive one in the first two columns, so a query of all-positive values
		// gives the largest difference on row 0 and a zero sum on row 31.
		reconfigure(2, 32);
		send(load_cmd(0, 0, 16'h8000));
		send(load_cmd(0, 1, 16'h8000));
		send(load_cmd(31, 0, 16'h7FFF));
		send(load_cmd(31, 1, 16'h7FFF));
		send(query_cmd(0, 16'h7FFF));
		send(query_cmd(1, 16'h7FFF));
		// A row that starts without column 0 adds onto the sums left from before.
		send(query_cmd(1, 16'h0000));
		// A column at or past the columns in use is ignored.
		send(query_cmd(5, pick_value()));
		send(query_cmd(63, pick_value()));
		// A repeated column 0 clears the row sums again, so only the second one counts.
		send(query_cmd(0, pick_value()));
		send(query_cmd(0, pick_value()));
		send(query_cmd(1, pick_value()));

		// Zero in both registers acts as one column and one reference row.
		reconfigure(0, 0);
		send(query_cmd(0, 16'h7FFF));
		send(query_cmd(1, pick_value()));
		send(query_cmd(0, 16'h8000));

		// Values past the maximum clamp to all columns and all rows, so the top
		// column is still inside the row and closes it.
		reconfigure(127, 63);
		send(query_cmd(0, 16'h7FFF));
		send(query_cmd(1, 16'h7FFF));
		send(query_cmd(TOP_COL, pick_value()));

		// The rest of the extremes of both registers.
		reconfigure(1, 1);
		send(query_cmd(0, pick_value()));
		reconfigure(64, 32);
		send(query_cmd(0, pick_value()));
		send(query_cmd(1, pick_value()));
		send(query_cmd(TOP_COL, pick_value()));

		// Random part, in three phases of sender idling. Most of it is whole query rows
		// with random values; the rest is stray loads, rows missing column 0, repeated
		// or ignored columns, and rows cut off partway.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 11 : (phase == 1) ? 59 : 0;
			count = 0;
			while (count < 12) begin
				if ($urandom_range(3) == 0) begin
					cols_pick = $urandom_range(4);
					rows_pick = $urandom_range(4);
					reconfigure(
						(cols_pick == 0) ? 0 :
						(cols_pick == 1) ? 1 :
						(cols_pick == 2) ? 64 :
						(cols_pick == 3) ? $urandom_range(65, 127) : 2,
						(rows_pick == 0) ? 0 :
						(rows_pick == 1) ? 1 :
						(rows_pick == 2) ? 32 :
						(rows_pick == 3) ? $urandom_range(33, 63) : $urandom_range(2, 31));
				end else if ($urandom_range(9) == 0) begin
					quiesce();
				end
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						send(load_cmd($urandom_range(REF_ROWS_DEF - 1),
							$urandom_range(MAX_COLS_DEF - 1), pick_value()));
						count++;
					end
				end
				ncols = eff_cols(cur_cols);
				kind = $urandom_range(19);
				first_col = (kind == 0 && ncols > 1) ? 1 : 0;
				for (int c = first_col; c < ncols; c++) begin
					// With every column in use the row jumps from column 1 to the top one.
					if (c > 1 && c != ncols - 1)
						continue;
					v = pick_value();
					send(query_cmd(c, v));
					count++;
					if (kind == 1 && $urandom_range(5) == 0) begin
						send(query_cmd(c, pick_value()));
						count++;
					end
					if (kind == 2 && ncols < MAX_COLS_DEF && $urandom_range(3) == 0) begin
						send(query_cmd($urandom_range(ncols, MAX_COLS_DEF - 1), pick_value()));
						count++;
					end
					if (kind == 3 && $urandom_range(3) == 0)
						break;
				end
			end
		end

		// Drain: every expected distance must arrive, then a quiet stretch catches any
		// result the block should not have produced.
		quiesce();
		repeat (60) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
